/* rtl/dga_pkg.sv */
// ----------------------------------------------------------------------------
// dga_pkg
// types and constants shared by the alignment core and its cost lookup
// ----------------------------------------------------------------------------
package dga_pkg;

  localparam int unsigned BaseW = 2;
  localparam int unsigned SymW  = 3;
  localparam int unsigned CostW = 14;
  localparam int unsigned CfgW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumCfg = 7;
  localparam logic [SymW-1:0] GapSym = 3'd4;
  localparam logic [CostW-1:0] CostMax = 14'h3fff;

  typedef enum logic [1:0] {
    REQ_LOAD_FIRST  = 2'd0,
    REQ_LOAD_SECOND = 2'd1,
    REQ_RUN         = 2'd2,
    REQ_NONE        = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAP = 3'd0,
    CFG_AC  = 3'd1,
    CFG_AG  = 3'd2,
    CFG_AT  = 3'd3,
    CFG_CG  = 3'd4,
    CFG_CT  = 3'd5,
    CFG_GT  = 3'd6,
    CFG_UNUSED = 3'd7
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL_TOP,
    ST_FILL_COL,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_TB_RD,
    ST_TB_RD2,
    ST_TB_RD3,
    ST_TB_DEC,
    ST_TAIL
  } state_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [BaseW-1:0] base;
  } in_req_t;

  typedef struct packed {
    logic [SymW-1:0]  top_symbol;
    logic [SymW-1:0]  bottom_symbol;
    logic             column_valid;
    logic [CostW-1:0] total_cost;
    logic             last;
  } out_req_t;

endpackage

/* rtl/dna_global_alignment_core.sv */
// ----------------------------------------------------------------------------
// dna_global_alignment_core
// global alignment of two base sequences with traceback, fill and traceback share each adder
// ----------------------------------------------------------------------------
// load requests are taken back to back while idle. run: the fill does one up read
// and one write per inner cell and one write per border cell, then each traceback
// step reads diag, up and left before its decision, and the tail is entered from
// the traceback read state. a waiting result holds traceback and tail; input stalls
// until the last column issues. reset clears lengths, indices, state and out_valid;
// stores, matrix and working cost registers are undefined until written.
module dna_global_alignment_core #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dga_pkg::in_req_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dga_pkg::out_req_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [dga_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dga_pkg::CfgW-1:0]      cfg_data_i
);

  localparam int unsigned Dim   = MAX_LEN + 1;
  localparam int unsigned Depth = Dim * Dim;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned LenW  = $clog2(MAX_LEN + 1);
  localparam int unsigned IdxW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CellRawW = $clog2((2 * MAX_LEN + 1) * (2 ** dga_pkg::CfgW));
  localparam int unsigned CellW = (CellRawW > dga_pkg::CostW) ? CellRawW : dga_pkg::CostW + 1;

  dga_pkg::state_e state_q, state_d;
  logic [LenW-1:0] n_q, n_d, m_q, m_d, i_q, i_d, j_q, j_d, i_dec, j_dec;
  logic [CellW-1:0] diag_q, diag_d, up_q, up_d, left_q, left_d, rb_q, rb_d;
  logic [dga_pkg::CostW-1:0] total_q, total_d;
  logic [dga_pkg::BaseW-1:0] seq_a_q [MAX_LEN];
  logic [dga_pkg::BaseW-1:0] seq_b_q [MAX_LEN];
  logic [dga_pkg::BaseW-1:0] xa, yb;
  logic [AddrW-1:0] raddr, waddr, row_base, up_addr, left_addr;
  logic [CellW-1:0] rdata, wdata;
  logic we;
  logic [dga_pkg::CfgW-1:0] gap, pair;
  logic out_valid_q, out_valid_d;
  dga_pkg::out_req_t out_q, out_d;
  logic accept, out_free;
  logic [CellW-1:0] up_src, left_src, cand_d, cand_u, cand_l, best;

  function automatic logic [dga_pkg::CostW-1:0] clamp_cost(logic [CellW-1:0] v);
    return (v > CellW'(dga_pkg::CostMax)) ? dga_pkg::CostMax : v[dga_pkg::CostW-1:0];
  endfunction

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != dga_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
  assign out_free = !out_valid_q || !out_stall_i;

  assign xa = seq_a_q[IdxW'(i_q - LenW'(1))];
  assign yb = seq_b_q[IdxW'(j_q - LenW'(1))];

  dga_cost_lut u_lut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .x_i(xa), .y_i(yb), .gap_o(gap), .pair_o(pair)
  );

  dga_matrix_ram #(.Depth(Depth), .AddrW(AddrW), .DataW(CellW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // sequence stores
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.req_type == dga_pkg::REQ_LOAD_FIRST && n_q < LenW'(MAX_LEN))
      seq_a_q[IdxW'(n_q)] <= in_data_i.base;
    if (accept && in_data_i.req_type == dga_pkg::REQ_LOAD_SECOND && m_q < LenW'(MAX_LEN))
      seq_b_q[IdxW'(m_q)] <= in_data_i.base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dga_pkg::ST_IDLE;
      n_q <= '0;
      m_q <= '0;
      i_q <= '0;
      j_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q <= n_d;
      m_q <= m_d;
      i_q <= i_d;
      j_q <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diag_q <= diag_d;
    up_q <= up_d;
    left_q <= left_d;
    rb_q <= rb_d;
    total_q <= total_d;
    out_q <= out_d;
  end

  assign row_base = AddrW'(i_q) * AddrW'(Dim);
  assign up_addr = row_base - AddrW'(Dim) + AddrW'(j_q);
  assign left_addr = row_base + AddrW'(j_q) - AddrW'(1);

  // shared add/compare unit, used by fill and traceback
  always_comb begin
    if (state_q == dga_pkg::ST_FILL_WR) begin
      up_src = rdata;
    end else if (state_q == dga_pkg::ST_FILL_COL) begin
      up_src = rb_q;
    end else begin
      up_src = up_q;
    end
    if (state_q == dga_pkg::ST_FILL_WR || state_q == dga_pkg::ST_FILL_TOP) begin
      left_src = left_q;
    end else begin
      left_src = rdata;
    end
    cand_d = diag_q + CellW'(pair);
    cand_u = up_src + CellW'(gap);
    cand_l = left_src + CellW'(gap);
    best = (cand_d < cand_u) ? cand_d : cand_u;
    best = (cand_l < best) ? cand_l : best;
  end

  always_comb begin
    state_d = state_q;
    n_d = n_q;
    m_d = m_q;
    i_d = i_q;
    j_d = j_q;
    diag_d = diag_q;
    up_d = up_q;
    left_d = left_q;
    rb_d = rb_q;
    total_d = total_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    raddr = '0;
    waddr = row_base + AddrW'(j_q);
    wdata = '0;
    we = 1'b0;
    i_dec = i_q - LenW'(1);
    j_dec = j_q - LenW'(1);
    case (state_q)
      dga_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data_i.req_type)
            dga_pkg::REQ_LOAD_FIRST: begin
              if (n_q < LenW'(MAX_LEN)) n_d = n_q + LenW'(1);
            end
            dga_pkg::REQ_LOAD_SECOND: begin
              if (m_q < LenW'(MAX_LEN)) m_d = m_q + LenW'(1);
            end
            dga_pkg::REQ_RUN: begin
              i_d = '0;
              j_d = '0;
              rb_d = '0;
              state_d = dga_pkg::ST_FILL_TOP;
            end
            default: ;
          endcase
        end
      end
      // top border row: running gap sum
      dga_pkg::ST_FILL_TOP: begin
        we = 1'b1;
        wdata = (j_q == '0) ? '0 : cand_l;
        left_d = wdata;
        if (j_q == m_q) begin
          if (n_q == '0) begin
            total_d = clamp_cost(wdata);
            state_d = dga_pkg::ST_TB_RD;
          end else begin
            i_d = LenW'(1);
            j_d = '0;
            state_d = dga_pkg::ST_FILL_COL;
          end
        end else begin
          j_d = j_q + LenW'(1);
        end
      end
      // left border cell of a row
      dga_pkg::ST_FILL_COL: begin
        we = 1'b1;
        wdata = cand_u;
        diag_d = rb_q;
        rb_d = cand_u;
        left_d = cand_u;
        if (m_q == '0) begin
          if (i_q == n_q) begin
            total_d = clamp_cost(cand_u);
            state_d = dga_pkg::ST_TB_RD;
          end else begin
            i_d = i_q + LenW'(1);
          end
        end else begin
          j_d = LenW'(1);
          state_d = dga_pkg::ST_FILL_RD;
        end
      end
      dga_pkg::ST_FILL_RD: begin
        raddr = up_addr;
        state_d = dga_pkg::ST_FILL_WR;
      end
      // up in rdata, diag and left held in registers
      dga_pkg::ST_FILL_WR: begin
        we = 1'b1;
        wdata = best;
        diag_d = rdata;
        left_d = best;
        if (j_q == m_q) begin
          if (i_q == n_q) begin
            total_d = clamp_cost(best);
            state_d = dga_pkg::ST_TB_RD;
          end else begin
            i_d = i_q + LenW'(1);
            j_d = '0;
            state_d = dga_pkg::ST_FILL_COL;
          end
        end else begin
          j_d = j_q + LenW'(1);
          state_d = dga_pkg::ST_FILL_RD;
        end
      end
      dga_pkg::ST_TB_RD: begin
        if (n_q == '0 && m_q == '0) begin
          if (out_free) begin
            out_d.top_symbol = dga_pkg::GapSym;
            out_d.bottom_symbol = dga_pkg::GapSym;
            out_d.column_valid = 1'b0;
            out_d.total_cost = '0;
            out_d.last = 1'b1;
            out_valid_d = 1'b1;
            state_d = dga_pkg::ST_IDLE;
          end
        end else if (i_q != '0 && j_q != '0) begin
          raddr = up_addr - AddrW'(1);
          state_d = dga_pkg::ST_TB_RD2;
        end else begin
          state_d = dga_pkg::ST_TAIL;
        end
      end
      dga_pkg::ST_TB_RD2: begin
        diag_d = rdata;
        raddr = up_addr;
        state_d = dga_pkg::ST_TB_RD3;
      end
      dga_pkg::ST_TB_RD3: begin
        up_d = rdata;
        raddr = left_addr;
        state_d = dga_pkg::ST_TB_DEC;
      end
      // left in rdata, held while the result slot is busy
      dga_pkg::ST_TB_DEC: begin
        raddr = left_addr;
        if (out_free) begin
          out_d.column_valid = 1'b1;
          out_d.total_cost = total_q;
          out_valid_d = 1'b1;
          if (cand_u < cand_d && cand_u < cand_l) begin
            out_d.top_symbol = {1'b0, xa};
            out_d.bottom_symbol = dga_pkg::GapSym;
            i_d = i_dec;
          end else if (cand_l < cand_d && cand_l < cand_u) begin
            out_d.top_symbol = dga_pkg::GapSym;
            out_d.bottom_symbol = {1'b0, yb};
            j_d = j_dec;
          end else begin
            out_d.top_symbol = {1'b0, xa};
            out_d.bottom_symbol = {1'b0, yb};
            i_d = i_dec;
            j_d = j_dec;
          end
          out_d.last = (i_d == '0 && j_d == '0);
          state_d = out_d.last ? dga_pkg::ST_IDLE : dga_pkg::ST_TB_RD;
        end
      end
      dga_pkg::ST_TAIL: begin
        if (out_free) begin
          out_d.column_valid = 1'b1;
          out_d.total_cost = total_q;
          out_valid_d = 1'b1;
          if (i_q != '0) begin
            out_d.top_symbol = {1'b0, xa};
            out_d.bottom_symbol = dga_pkg::GapSym;
            i_d = i_dec;
          end else begin
            out_d.top_symbol = dga_pkg::GapSym;
            out_d.bottom_symbol = {1'b0, yb};
            j_d = j_dec;
          end
          out_d.last = (i_d == '0 && j_d == '0);
          state_d = out_d.last ? dga_pkg::ST_IDLE : dga_pkg::ST_TAIL;
        end
      end
      default: state_d = dga_pkg::ST_IDLE;
    endcase
    // both lengths clear when a run ends
    if (state_q != dga_pkg::ST_IDLE && state_d == dga_pkg::ST_IDLE) begin
      n_d = '0;
      m_d = '0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= LenW'(MAX_LEN) && m_q <= LenW'(MAX_LEN))
    else $error("length overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.column_valid |-> out_data_o.last)
    else $error("empty run result not marked last");

endmodule

/* rtl/dga_cost_lut.sv */
// ----------------------------------------------------------------------------
// dga_cost_lut
// pair cost registers and lookup of the mismatch cost of two bases
// ----------------------------------------------------------------------------
module dga_cost_lut (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dga_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dga_pkg::CfgW-1:0]     cfg_data_i,
  input  logic [dga_pkg::BaseW-1:0]    x_i,
  input  logic [dga_pkg::BaseW-1:0]    y_i,
  output logic [dga_pkg::CfgW-1:0]     gap_o,
  output logic [dga_pkg::CfgW-1:0]     pair_o
);

  logic [dga_pkg::CfgW-1:0] cost_q [dga_pkg::NumCfg];
  logic [dga_pkg::BaseW-1:0] lo, hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q[0] <= 8'd30;
      cost_q[1] <= 8'd110;
      cost_q[2] <= 8'd48;
      cost_q[3] <= 8'd94;
      cost_q[4] <= 8'd118;
      cost_q[5] <= 8'd48;
      cost_q[6] <= 8'd110;
    end else if (cfg_we_i && cfg_idx_i != dga_pkg::CFG_UNUSED) begin
      cost_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign gap_o = cost_q[dga_pkg::CFG_GAP];

  always_comb begin
    lo = (x_i < y_i) ? x_i : y_i;
    hi = (x_i < y_i) ? y_i : x_i;
    pair_o = '0;
    if (lo != hi) begin
      case ({lo, hi})
        4'b0001: pair_o = cost_q[dga_pkg::CFG_AC];
        4'b0010: pair_o = cost_q[dga_pkg::CFG_AG];
        4'b0011: pair_o = cost_q[dga_pkg::CFG_AT];
        4'b0110: pair_o = cost_q[dga_pkg::CFG_CG];
        4'b0111: pair_o = cost_q[dga_pkg::CFG_CT];
        default: pair_o = cost_q[dga_pkg::CFG_GT];
      endcase
    end
  end

endmodule

/* rtl/dga_matrix_ram.sv */
// ----------------------------------------------------------------------------
// dga_matrix_ram
// cost matrix memory, one write and one registered read port
// ----------------------------------------------------------------------------
module dga_matrix_ram #(
  parameter int unsigned Depth = 1089,
  parameter int unsigned AddrW = 11,
  parameter int unsigned DataW = 15
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AddrW-1:0]              waddr_i,
  input  logic [DataW-1:0]              wdata_i,
  input  logic [AddrW-1:0]              raddr_i,
  output logic [DataW-1:0]              rdata_o
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule
